### hw/rtl/dtf_pkg.sv
// Shared types, constants and helpers for the date text field parser.
// No dependencies; compile before the interfaces and all modules.
package dtf_pkg;

    // Longest string position tracked; the position count saturates here.
    localparam int MAX_LENGTH = 255;
    localparam int IDX_W      = $clog2(MAX_LENGTH + 1);
    localparam int ACC_W      = 14;
    localparam int SLOT_W     = 2;
    localparam int CNT_W      = 3;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 2;

    typedef logic [ACC_W-1:0]         t_acc;
    typedef logic [SLOT_W-1:0]        t_slot;
    typedef logic signed [CNT_W-1:0]  t_cnt;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [7:0]               t_char;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_DAY_SLOT   = 2'd0;
    localparam t_cfg_idx CFG_MONTH_SLOT = 2'd1;
    localparam t_cfg_idx CFG_YEAR_SLOT  = 2'd2;
    localparam t_cfg_idx CFG_EPOCH_YEAR = 2'd3;

    // Reset values of the configuration registers
    localparam t_slot DAY_SLOT_RESET   = 2'd2;
    localparam t_slot MONTH_SLOT_RESET = 2'd1;
    localparam t_slot YEAR_SLOT_RESET  = 2'd3;
    localparam int    EPOCH_RESET      = 1900;

    // Value limits
    localparam t_acc ACC_MAX   = 14'd9999;
    localparam t_acc EPOCH_MAX = 14'd9999;
    localparam t_acc CENTURY   = 14'd100;

    // Character codes
    localparam t_char CH_ZERO  = 8'd48;
    localparam t_char CH_NINE  = 8'd57;
    localparam t_char CH_SPACE = 8'd32;

    // Slot counter codes
    localparam t_cnt CNT_ACTIVE = 3'sd1;
    localparam t_cnt CNT_FLOOR  = -3'sd1;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 43699
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    // Shift one decimal digit into an accumulator, saturating at ACC_MAX.
    function automatic t_acc push_digit(input t_acc acc, input logic [3:0] d);
        logic [ACC_W+3:0] v;
        v = {acc, 3'b000} + {1'b0, acc, 1'b0} + (ACC_W+4)'(d);
        return (v > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
    endfunction

    // Move a slot counter down one place, holding at the floor.
    function automatic t_cnt step_down(input t_cnt c);
        return (c == CNT_FLOOR) ? CNT_FLOOR : t_cnt'(c - CNT_ACTIVE);
    endfunction

endpackage

### hw/rtl/dtf_char_if.sv
// Character channel: one string character per beat.
// Depends on dtf_pkg for the payload types.
interface dtf_char_if;
    logic            valid;
    logic            ready;
    dtf_pkg::t_char  char_code;
    logic            last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

### hw/rtl/dtf_date_if.sv
// Result channel: parsed day, month, year and stop position per beat.
// Depends on dtf_pkg for the payload types.
interface dtf_date_if;
    logic           valid;
    logic           ready;
    dtf_pkg::t_acc  day;
    dtf_pkg::t_acc  month;
    dtf_pkg::t_acc  year;
    dtf_pkg::t_pos  stop_position;

    modport source (output valid, output day, output month, output year,
                    output stop_position, input ready);
    modport sink   (input valid, input day, input month, input year,
                    input stop_position, output ready);
endinterface

### hw/rtl/dtf_year_window.sv
// Epoch register and two-digit year windowing.
// Depends on dtf_pkg.
module dtf_year_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_epoch_we,
    input  dtf_pkg::t_acc  i_epoch_data,
    input  dtf_pkg::t_acc  i_year,
    output dtf_pkg::t_acc  o_year
);
    import dtf_pkg::*;

    localparam int Q_W  = 7;
    localparam int LO_W = 7;
    localparam int PROD_W = ACC_W + 13;

    t_acc              w_epoch_clamp;
    logic [PROD_W-1:0] w_prod;
    t_acc              r_epoch;
    logic [Q_W-1:0]    r_epoch_q;
    t_acc              r_base;
    logic [LO_W-1:0]   r_lo;
    t_acc              n_base;
    t_acc              w_lo_full;
    t_acc              w_offset;

    assign w_epoch_clamp = (i_epoch_data > EPOCH_MAX) ? EPOCH_MAX : i_epoch_data;
    assign w_prod        = PROD_W'(w_epoch_clamp) * PROD_W'(RECIP_100);

    // Century start comes out of a constant multiply by 100.
    assign n_base    = t_acc'(r_epoch_q) * CENTURY;
    assign w_lo_full = r_epoch - n_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch   <= t_acc'(EPOCH_RESET);
            r_epoch_q <= Q_W'(EPOCH_RESET / 100);
            r_base    <= t_acc'((EPOCH_RESET / 100) * 100);
            r_lo      <= LO_W'(EPOCH_RESET % 100);
        end else begin
            if (i_epoch_we) begin
                r_epoch   <= w_epoch_clamp;
                r_epoch_q <= w_prod[RECIP_SHIFT +: Q_W];
            end
            r_base <= n_base;
            r_lo   <= w_lo_full[LO_W-1:0];
        end
    end

    assign w_offset = (i_year[LO_W-1:0] >= r_lo) ? r_base : t_acc'(r_base + CENTURY);
    assign o_year   = (i_year < CENTURY) ? t_acc'(i_year + w_offset) : i_year;

endmodule

### hw/rtl/date_text_field_parser.sv
// Top level of the date text field parser: character scan, result stages.
// Depends on dtf_pkg, dtf_char_if, dtf_date_if and dtf_year_window.
//
//  channel   dir  beat payload                          ends when
//  i_char    in   char_code[7:0], last                  valid & ready
//  o_date    out  day, month, year [13:0], stop_pos[7:0] valid & ready
//  i_cfg_*   in   index[1:0], data[13:0]                we high
//
// One character per cycle while the input is not stalled. Each beat updates
// the slot counters and accumulators in the cycle it is accepted; a beat with
// last set loads a capture stage, and the year window is applied on the way
// into the output register.
// Reset is synchronous, active low; it restores the slot and epoch registers
// and clears the string state. Input stalls only when both result stages are
// full and the sink holds ready low; the scan itself never waits.
module date_text_field_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dtf_char_if.sink           i_char,
    dtf_date_if.source         o_date,
    input  logic               i_cfg_we,
    input  dtf_pkg::t_cfg_idx  i_cfg_index,
    input  dtf_pkg::t_acc      i_cfg_data
);
    import dtf_pkg::*;

    // Configuration
    t_slot r_day_slot, r_month_slot, r_year_slot;
    logic  w_epoch_we;

    // String state
    t_cnt  r_day_cnt, r_month_cnt, r_year_cnt;
    t_acc  r_day_acc, r_month_acc, r_year_acc;
    logic  r_in_sep, r_finished;
    t_idx  r_char_idx, r_stop_idx;

    // Updated string state for the current beat
    t_cnt  n_day_cnt, n_month_cnt, n_year_cnt;
    t_acc  n_day_acc, n_month_acc, n_year_acc;
    logic  n_in_sep, n_finished;
    t_idx  n_char_idx, n_stop_idx;
    t_idx  w_pos_idx;

    // Helpers
    logic  w_accept, w_first, w_digit, w_all_set;
    t_cnt  w_day_cnt, w_month_cnt, w_year_cnt;
    logic [3:0] w_digit_val;

    // Capture stage and output stage
    logic  r_s1_valid;
    t_acc  r_s1_day, r_s1_month, r_s1_year;
    t_pos  r_s1_pos;
    logic  w_s1_move;
    logic  r_o_valid;
    t_acc  r_o_day, r_o_month, r_o_year;
    t_pos  r_o_pos;
    t_acc  w_win_year;

    // Configuration writes: slots here, epoch inside the window unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day_slot   <= DAY_SLOT_RESET;
            r_month_slot <= MONTH_SLOT_RESET;
            r_year_slot  <= YEAR_SLOT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DAY_SLOT:   r_day_slot   <= i_cfg_data[SLOT_W-1:0];
                CFG_MONTH_SLOT: r_month_slot <= i_cfg_data[SLOT_W-1:0];
                CFG_YEAR_SLOT:  r_year_slot  <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_epoch_we = i_cfg_we && (i_cfg_index == CFG_EPOCH_YEAR);

    // Handshake: advance the capture stage when the output register frees up
    assign w_s1_move     = r_s1_valid && (!r_o_valid || o_date.ready);
    assign i_char.ready  = !r_s1_valid || w_s1_move;
    assign w_accept      = i_char.valid && i_char.ready;

    // Counters reload from the slot registers on the first character
    assign w_first     = (r_char_idx == '0);
    assign w_day_cnt   = w_first ? t_cnt'({1'b0, r_day_slot})   : r_day_cnt;
    assign w_month_cnt = w_first ? t_cnt'({1'b0, r_month_slot}) : r_month_cnt;
    assign w_year_cnt  = w_first ? t_cnt'({1'b0, r_year_slot})  : r_year_cnt;

    assign w_digit     = (i_char.char_code >= CH_ZERO) && (i_char.char_code <= CH_NINE);
    assign w_digit_val = 4'(i_char.char_code - CH_ZERO);
    assign w_all_set   = (r_day_acc != '0) && (r_month_acc != '0) && (r_year_acc != '0);

    // Per-character update
    always_comb begin
        n_day_cnt   = w_day_cnt;
        n_month_cnt = w_month_cnt;
        n_year_cnt  = w_year_cnt;
        n_day_acc   = r_day_acc;
        n_month_acc = r_month_acc;
        n_year_acc  = r_year_acc;
        n_in_sep    = r_in_sep;
        n_finished  = r_finished;
        n_stop_idx  = r_stop_idx;
        n_char_idx  = r_char_idx;

        if (!r_finished) begin
            if (w_digit) begin
                // Feed the digit to the field whose counter sits at one
                if (w_day_cnt == CNT_ACTIVE) begin
                    n_day_acc = push_digit(r_day_acc, w_digit_val);
                end else if (w_month_cnt == CNT_ACTIVE) begin
                    n_month_acc = push_digit(r_month_acc, w_digit_val);
                end else if (w_year_cnt == CNT_ACTIVE) begin
                    n_year_acc = push_digit(r_year_acc, w_digit_val);
                end
                n_in_sep = 1'b0;
            end else if (w_all_set) begin
                // All three fields present: stop here
                n_finished = 1'b1;
                n_stop_idx = r_char_idx;
            end else if (i_char.char_code != CH_SPACE) begin
                // First separator after a digit moves every field on
                if (!r_in_sep) begin
                    n_day_cnt   = step_down(w_day_cnt);
                    n_month_cnt = step_down(w_month_cnt);
                    n_year_cnt  = step_down(w_year_cnt);
                end
                n_in_sep = 1'b1;
            end
        end

        if (r_char_idx < t_idx'(MAX_LENGTH)) begin
            n_char_idx = t_idx'(r_char_idx + 1'b1);
        end
    end

    assign w_pos_idx = n_finished ? n_stop_idx : n_char_idx;

    // String state: clear after the last character of each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_char.last)) begin
            r_day_cnt   <= '0;
            r_month_cnt <= '0;
            r_year_cnt  <= '0;
            r_day_acc   <= '0;
            r_month_acc <= '0;
            r_year_acc  <= '0;
            r_in_sep    <= 1'b1;
            r_finished  <= 1'b0;
            r_char_idx  <= '0;
            r_stop_idx  <= '0;
        end else if (w_accept) begin
            r_day_cnt   <= n_day_cnt;
            r_month_cnt <= n_month_cnt;
            r_year_cnt  <= n_year_cnt;
            r_day_acc   <= n_day_acc;
            r_month_acc <= n_month_acc;
            r_year_acc  <= n_year_acc;
            r_in_sep    <= n_in_sep;
            r_finished  <= n_finished;
            r_char_idx  <= n_char_idx;
            r_stop_idx  <= n_stop_idx;
        end
    end

    // Capture stage: hold the raw fields of a finished string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept && i_char.last) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_char.last) begin
            r_s1_day   <= n_day_acc;
            r_s1_month <= n_month_acc;
            r_s1_year  <= n_year_acc;
            r_s1_pos   <= (32'(w_pos_idx) > 32'd255) ? 8'd255 : t_pos'(w_pos_idx);
        end
    end

    // Two-digit years go into the epoch window
    dtf_year_window u_year_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_epoch_we   (w_epoch_we),
        .i_epoch_data (i_cfg_data),
        .i_year       (r_s1_year),
        .o_year       (w_win_year)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_o_valid <= 1'b1;
        end else if (o_date.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_o_day   <= r_s1_day;
            r_o_month <= r_s1_month;
            r_o_year  <= w_win_year;
            r_o_pos   <= r_s1_pos;
        end
    end

    assign o_date.valid         = r_o_valid;
    assign o_date.day           = r_o_day;
    assign o_date.month         = r_o_month;
    assign o_date.year          = r_o_year;
    assign o_date.stop_position = r_o_pos;

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day_cnt >= CNT_FLOOR) && (r_month_cnt >= CNT_FLOOR) && (r_year_cnt >= CNT_FLOOR))
        else $error("slot counter below floor");

    a_acc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day_acc <= ACC_MAX) && (r_month_acc <= ACC_MAX) && (r_year_acc <= ACC_MAX))
        else $error("accumulator above saturation limit");

    a_finished_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_day_acc != '0) && (r_month_acc != '0) && (r_year_acc != '0))
        else $error("parse stopped with an empty field");

    a_stop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_stop_idx <= r_char_idx))
        else $error("stop position ahead of character count");

endmodule
